[src/ppal_pkg.sv]
// ppal_pkg: shared constants, types and sequencer codes for the pH probe
// averaging block. No dependencies; the RTL uses scoped names, the test imports it.

package ppal_pkg;

    // Block averaging and ADC scaling
    localparam int AVG_SAMPLES    = 250;
    localparam int ADC_FULL_SCALE = 4096;
    localparam int AVG_HALF       = AVG_SAMPLES / 2;

    // Field widths
    localparam int CODE_W     = 12;
    localparam int VOLT_W     = 20;
    localparam int PH_W       = 24;
    localparam int SUM_W      = 28;
    localparam int CNT_W      = $clog2(AVG_SAMPLES + 1);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // volts = code * cal * VOLT_NUM / (vref * VOLT_DEN), Q4.16
    localparam longint VOLT_NUM = 33 * 65536;
    localparam longint VOLT_DEN = ADC_FULL_SCALE * 10;

    // Shared divider geometry
    localparam int DIV_QW    = VOLT_W;
    localparam int DIV_DW    = CODE_W + $clog2(VOLT_DEN);
    localparam int DIV_NW    = 2 * CODE_W + $clog2(VOLT_NUM);
    localparam int DIV_SH_W  = DIV_DW + DIV_QW - 1;
    localparam int DIV_CNT_W = $clog2(DIV_QW + 1);

    // Shared multiplier geometry
    localparam int MUL_AW = PH_W + 1;
    localparam int MUL_BW = VOLT_W + 1;
    localparam int MUL_PW = PH_W + VOLT_W + 1;

    // Configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VREF_FACTORY_CODE = 3'd0,
        REG_SOIL_SLOPE        = 3'd1,
        REG_SOIL_OFFSET       = 3'd2,
        REG_WATER_SLOPE       = 3'd3,
        REG_WATER_OFFSET      = 3'd4,
        REG_CALIBRATING       = 3'd5,
        REG_MEASURE_RAW       = 3'd6
    } cfg_reg_t;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL_S,
        ST_DIV_S_GO,
        ST_DIV_S_WAIT,
        ST_MUL_W,
        ST_DIV_W_GO,
        ST_DIV_W_WAIT,
        ST_ACCUM,
        ST_AVG_S_GO,
        ST_AVG_S_WAIT,
        ST_AVG_W_GO,
        ST_AVG_W_WAIT,
        ST_PH_S_MUL,
        ST_PH_S_ADD,
        ST_PH_W_MUL,
        ST_PH_W_ADD,
        ST_FINISH
    } state_t;

    // Divider request and response
    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_QW-1:0] quot;
    } div_rsp_t;

endpackage

[src/ppal_if.sv]
// ppal_if: valid/ready channel interfaces for scans, results and register writes.
// Depends on ppal_pkg for field widths.

interface ppal_scan_if;
    logic                          valid;
    logic                          ready;
    logic [ppal_pkg::CODE_W-1:0]   vref_code;
    logic [ppal_pkg::CODE_W-1:0]   soil_code;
    logic [ppal_pkg::CODE_W-1:0]   water_code;

    modport source (output valid, vref_code, soil_code, water_code, input ready);
    modport sink   (input valid, vref_code, soil_code, water_code, output ready);
endinterface

interface ppal_result_if;
    logic                               valid;
    logic                               ready;
    logic                               status;
    logic        [ppal_pkg::VOLT_W-1:0] soil_volts;
    logic        [ppal_pkg::VOLT_W-1:0] water_volts;
    logic signed [ppal_pkg::PH_W-1:0]   soil_ph_out;
    logic signed [ppal_pkg::PH_W-1:0]   water_ph_out;
    logic signed [ppal_pkg::PH_W-1:0]   prev_soil_ph_out;
    logic signed [ppal_pkg::PH_W-1:0]   prev_water_ph_out;
    logic                               ph_updated;

    modport source (output valid, status, soil_volts, water_volts, soil_ph_out,
                    water_ph_out, prev_soil_ph_out, prev_water_ph_out, ph_updated,
                    input ready);
    modport sink   (input valid, status, soil_volts, water_volts, soil_ph_out,
                    water_ph_out, prev_soil_ph_out, prev_water_ph_out, ph_updated,
                    output ready);
endinterface

interface ppal_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [ppal_pkg::CFG_IDX_W-1:0]    index;
    logic [ppal_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[src/ph_probe_average_linear.sv]
// ph_probe_average_linear: top level; sequencer, shared multiplier, block state.
// Depends on ppal_pkg, the ppal_if interfaces and ppal_div.
//
//   channel | dir | beat
//   --------+-----+-----------------------------------------------------------
//   cfg     | in  | register index and write data
//   scan    | in  | vref_code, soil_code, water_code
//   result  | out | status, volts, pH, previous pH, ph_updated
//
// A result loads once the soil and water volts of its scan are computed, after
// the averages and pH lines too when it closes a block of AVG_SAMPLES, and with
// no arithmetic when the reference code is zero; the next scan is taken in the
// cycle after the load. The 20-step divider dominates: two volts divisions per
// scan, two more for the averages. Reset clears all sums, averages and pH and
// loads the register defaults. A new scan is taken while a result still waits;
// the next result waits in the sequencer until the output register frees.

module ph_probe_average_linear
(
    input  logic          clk,
    input  logic          rst_n,
    ppal_cfg_if.sink      cfg,
    ppal_scan_if.sink     scan,
    ppal_result_if.source result
);

    localparam int CW = ppal_pkg::CODE_W;
    localparam int VW = ppal_pkg::VOLT_W;
    localparam int PW = ppal_pkg::PH_W;
    localparam int SW = ppal_pkg::SUM_W;
    localparam int NW = ppal_pkg::DIV_NW;
    localparam int DW = ppal_pkg::DIV_DW;

    ppal_pkg::state_t state_reg, state_next;

    // configuration
    logic        [CW-1:0] vref_cal_reg;
    logic signed [PW-1:0] soil_slope_reg, soil_offset_reg;
    logic signed [PW-1:0] water_slope_reg, water_offset_reg;
    logic                 calibrating_reg, measure_raw_reg;

    // block state
    logic [ppal_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [SW-1:0]        soil_sum_reg, soil_sum_next, water_sum_reg, water_sum_next;
    logic [VW-1:0]        soil_avg_reg, soil_avg_next, water_avg_reg, water_avg_next;
    logic signed [PW-1:0] soil_ph_reg, soil_ph_next, water_ph_reg, water_ph_next;
    logic signed [PW-1:0] prev_soil_reg, prev_soil_next, prev_water_reg, prev_water_next;
    logic                 status_reg, status_next, updated_reg, updated_next;

    // scan payload and intermediates
    logic [CW-1:0]        vref_code_reg, vref_code_next;
    logic [CW-1:0]        soil_code_reg, soil_code_next, water_code_reg, water_code_next;
    logic [VW-1:0]        sv_reg, sv_next, wv_reg, wv_next;
    logic signed [ppal_pkg::MUL_PW-1:0] mul_reg, mul_next;

    // result register
    logic                 res_valid_reg, res_valid_next, res_load;
    logic                 res_status_reg, res_updated_reg;
    logic [VW-1:0]        res_soil_v_reg, res_water_v_reg;
    logic signed [PW-1:0] res_soil_ph_reg, res_water_ph_reg;
    logic signed [PW-1:0] res_prev_soil_reg, res_prev_water_reg;

    // shared units
    logic signed [ppal_pkg::MUL_AW-1:0] mul_a;
    logic signed [ppal_pkg::MUL_BW-1:0] mul_b;
    logic signed [ppal_pkg::MUL_AW+ppal_pkg::MUL_BW-1:0] mul_full;
    ppal_pkg::div_req_t div_req;
    ppal_pkg::div_rsp_t div_rsp;

    logic [DW-1:0]             volt_den;
    logic [NW-1:0]             volt_num;
    logic [ppal_pkg::CNT_W-1:0] cnt_inc;
    logic                      scan_ready;

    function automatic logic [SW-1:0] sum_sat(input logic [SW-1:0] s, input logic [VW-1:0] v);
        logic [SW:0] t;
        t = (SW+1)'(s) + (SW+1)'(v);
        return t[SW] ? '1 : t[SW-1:0];
    endfunction

    // round half up of slope*avg in Q16, add the offset, clamp to Q8.16
    function automatic logic signed [PW-1:0] ph_line(
        input logic signed [ppal_pkg::MUL_PW-1:0] prod,
        input logic signed [PW-1:0]               off
    );
        logic signed [ppal_pkg::MUL_PW-1:0]    p;
        logic signed [ppal_pkg::MUL_PW-17:0]   q;
        logic signed [ppal_pkg::MUL_PW-16:0]   r;
        logic signed [PW-1:0]                  res;
        p = prod + ppal_pkg::MUL_PW'(32768);
        q = (ppal_pkg::MUL_PW-16)'(p >>> 16);
        r = (ppal_pkg::MUL_PW-15)'(q) + (ppal_pkg::MUL_PW-15)'(off);
        if (r > (ppal_pkg::MUL_PW-15)'(signed'(24'sh7FFFFF)))
            res = 24'sh7FFFFF;
        else if (r < (ppal_pkg::MUL_PW-15)'(signed'(24'sh800000)))
            res = 24'sh800000;
        else
            res = r[PW-1:0];
        return res;
    endfunction

    ppal_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Volts operands: numerator scaled plus half the divisor for rounding
    assign volt_den = DW'(vref_code_reg) * DW'(ppal_pkg::VOLT_DEN);
    assign volt_num = NW'(mul_reg[2*CW-1:0]) * NW'(ppal_pkg::VOLT_NUM)
                    + NW'(volt_den >> 1);
    assign cnt_inc  = cnt_reg + ppal_pkg::CNT_W'(1);
    assign mul_full = mul_a * mul_b;
    assign mul_next = $signed(mul_full[ppal_pkg::MUL_PW-1:0]);

    // Sequencer: next state, unit operands and state updates
    always_comb
    begin
        state_next      = state_reg;
        scan_ready      = 1'b0;
        res_load        = 1'b0;
        mul_a           = '0;
        mul_b           = '0;
        div_req         = '0;
        cnt_next        = cnt_reg;
        soil_sum_next   = soil_sum_reg;
        water_sum_next  = water_sum_reg;
        soil_avg_next   = soil_avg_reg;
        water_avg_next  = water_avg_reg;
        soil_ph_next    = soil_ph_reg;
        water_ph_next   = water_ph_reg;
        prev_soil_next  = prev_soil_reg;
        prev_water_next = prev_water_reg;
        status_next     = status_reg;
        updated_next    = updated_reg;
        vref_code_next  = vref_code_reg;
        soil_code_next  = soil_code_reg;
        water_code_next = water_code_reg;
        sv_next         = sv_reg;
        wv_next         = wv_reg;

        case (state_reg)
            ppal_pkg::ST_IDLE:
            begin
                scan_ready = 1'b1;
                if (scan.valid)
                begin
                    vref_code_next  = scan.vref_code;
                    soil_code_next  = scan.soil_code;
                    water_code_next = scan.water_code;
                    updated_next    = 1'b0;
                    // zero reference: report and touch nothing
                    if (scan.vref_code == '0)
                    begin
                        status_next = 1'b1;
                        state_next  = ppal_pkg::ST_FINISH;
                    end
                    else
                    begin
                        status_next = 1'b0;
                        state_next  = ppal_pkg::ST_MUL_S;
                    end
                end
            end
            ppal_pkg::ST_MUL_S:
            begin
                mul_a      = ppal_pkg::MUL_AW'(soil_code_reg);
                mul_b      = ppal_pkg::MUL_BW'(vref_cal_reg);
                state_next = ppal_pkg::ST_DIV_S_GO;
            end
            ppal_pkg::ST_DIV_S_GO:
            begin
                div_req.start = 1'b1;
                div_req.num   = volt_num;
                div_req.den   = volt_den;
                state_next    = ppal_pkg::ST_DIV_S_WAIT;
            end
            ppal_pkg::ST_DIV_S_WAIT:
            begin
                if (div_rsp.done)
                begin
                    sv_next    = div_rsp.quot;
                    state_next = ppal_pkg::ST_MUL_W;
                end
            end
            ppal_pkg::ST_MUL_W:
            begin
                mul_a      = ppal_pkg::MUL_AW'(water_code_reg);
                mul_b      = ppal_pkg::MUL_BW'(vref_cal_reg);
                state_next = ppal_pkg::ST_DIV_W_GO;
            end
            ppal_pkg::ST_DIV_W_GO:
            begin
                div_req.start = 1'b1;
                div_req.num   = volt_num;
                div_req.den   = volt_den;
                state_next    = ppal_pkg::ST_DIV_W_WAIT;
            end
            ppal_pkg::ST_DIV_W_WAIT:
            begin
                if (div_rsp.done)
                begin
                    wv_next    = div_rsp.quot;
                    state_next = ppal_pkg::ST_ACCUM;
                end
            end
            ppal_pkg::ST_ACCUM:
            begin
                if (calibrating_reg)
                begin
                    // calibration: hold the block, force pH to zero; raw mode shows the scan volts
                    if (measure_raw_reg)
                    begin
                        soil_avg_next  = sv_reg;
                        water_avg_next = wv_reg;
                    end
                    soil_ph_next  = '0;
                    water_ph_next = '0;
                    state_next    = ppal_pkg::ST_FINISH;
                end
                else
                begin
                    soil_sum_next  = sum_sat(soil_sum_reg, sv_reg);
                    water_sum_next = sum_sat(water_sum_reg, wv_reg);
                    if (cnt_inc >= ppal_pkg::CNT_W'(ppal_pkg::AVG_SAMPLES))
                    begin
                        cnt_next   = '0;
                        state_next = ppal_pkg::ST_AVG_S_GO;
                    end
                    else
                    begin
                        cnt_next   = cnt_inc;
                        state_next = ppal_pkg::ST_FINISH;
                    end
                end
            end
            ppal_pkg::ST_AVG_S_GO:
            begin
                div_req.start = 1'b1;
                div_req.num   = NW'(soil_sum_reg) + NW'(ppal_pkg::AVG_HALF);
                div_req.den   = DW'(ppal_pkg::AVG_SAMPLES);
                state_next    = ppal_pkg::ST_AVG_S_WAIT;
            end
            ppal_pkg::ST_AVG_S_WAIT:
            begin
                if (div_rsp.done)
                begin
                    soil_avg_next = div_rsp.quot;
                    state_next    = ppal_pkg::ST_AVG_W_GO;
                end
            end
            ppal_pkg::ST_AVG_W_GO:
            begin
                div_req.start = 1'b1;
                div_req.num   = NW'(water_sum_reg) + NW'(ppal_pkg::AVG_HALF);
                div_req.den   = DW'(ppal_pkg::AVG_SAMPLES);
                state_next    = ppal_pkg::ST_AVG_W_WAIT;
            end
            ppal_pkg::ST_AVG_W_WAIT:
            begin
                if (div_rsp.done)
                begin
                    water_avg_next = div_rsp.quot;
                    soil_sum_next  = '0;
                    water_sum_next = '0;
                    state_next     = ppal_pkg::ST_PH_S_MUL;
                end
            end
            ppal_pkg::ST_PH_S_MUL:
            begin
                mul_a           = ppal_pkg::MUL_AW'(soil_slope_reg);
                mul_b           = ppal_pkg::MUL_BW'(soil_avg_reg);
                prev_soil_next  = soil_ph_reg;
                prev_water_next = water_ph_reg;
                state_next      = ppal_pkg::ST_PH_S_ADD;
            end
            ppal_pkg::ST_PH_S_ADD:
            begin
                soil_ph_next = ph_line(mul_reg, soil_offset_reg);
                state_next   = ppal_pkg::ST_PH_W_MUL;
            end
            ppal_pkg::ST_PH_W_MUL:
            begin
                mul_a      = ppal_pkg::MUL_AW'(water_slope_reg);
                mul_b      = ppal_pkg::MUL_BW'(water_avg_reg);
                state_next = ppal_pkg::ST_PH_W_ADD;
            end
            ppal_pkg::ST_PH_W_ADD:
            begin
                water_ph_next = ph_line(mul_reg, water_offset_reg);
                updated_next  = 1'b1;
                state_next    = ppal_pkg::ST_FINISH;
            end
            ppal_pkg::ST_FINISH:
            begin
                // hand over once the output register is free
                if (!res_valid_reg || result.ready)
                begin
                    res_load   = 1'b1;
                    state_next = ppal_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ppal_pkg::ST_IDLE;
            end
        endcase
    end

    // Output register valid: set on load, drop when the beat is taken
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (res_load)
            res_valid_next = 1'b1;
        else if (result.ready)
            res_valid_next = 1'b0;
    end

    // State, block state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ppal_pkg::ST_IDLE;
            res_valid_reg    <= 1'b0;
            cnt_reg          <= '0;
            soil_sum_reg     <= '0;
            water_sum_reg    <= '0;
            soil_avg_reg     <= '0;
            water_avg_reg    <= '0;
            soil_ph_reg      <= '0;
            water_ph_reg     <= '0;
            prev_soil_reg    <= '0;
            prev_water_reg   <= '0;
            status_reg       <= 1'b0;
            updated_reg      <= 1'b0;
            vref_cal_reg     <= CW'(1527);
            soil_slope_reg   <= '0;
            soil_offset_reg  <= '0;
            water_slope_reg  <= '0;
            water_offset_reg <= '0;
            calibrating_reg  <= 1'b0;
            measure_raw_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            res_valid_reg  <= res_valid_next;
            cnt_reg        <= cnt_next;
            soil_sum_reg   <= soil_sum_next;
            water_sum_reg  <= water_sum_next;
            soil_avg_reg   <= soil_avg_next;
            water_avg_reg  <= water_avg_next;
            soil_ph_reg    <= soil_ph_next;
            water_ph_reg   <= water_ph_next;
            prev_soil_reg  <= prev_soil_next;
            prev_water_reg <= prev_water_next;
            status_reg     <= status_next;
            updated_reg    <= updated_next;

            // register write beat; unknown indexes drop
            if (cfg.valid)
            begin
                case (cfg.index)
                    ppal_pkg::REG_VREF_FACTORY_CODE: vref_cal_reg     <= cfg.data[CW-1:0];
                    ppal_pkg::REG_SOIL_SLOPE:        soil_slope_reg   <= cfg.data;
                    ppal_pkg::REG_SOIL_OFFSET:       soil_offset_reg  <= cfg.data;
                    ppal_pkg::REG_WATER_SLOPE:       water_slope_reg  <= cfg.data;
                    ppal_pkg::REG_WATER_OFFSET:      water_offset_reg <= cfg.data;
                    ppal_pkg::REG_CALIBRATING:       calibrating_reg  <= cfg.data[0];
                    ppal_pkg::REG_MEASURE_RAW:       measure_raw_reg  <= cfg.data[0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Scan payload, intermediates and result fields
    always_ff @(posedge clk)
    begin
        vref_code_reg  <= vref_code_next;
        soil_code_reg  <= soil_code_next;
        water_code_reg <= water_code_next;
        sv_reg         <= sv_next;
        wv_reg         <= wv_next;
        mul_reg        <= mul_next;
        if (res_load)
        begin
            res_status_reg     <= status_reg;
            res_updated_reg    <= updated_reg;
            res_soil_v_reg     <= soil_avg_reg;
            res_water_v_reg    <= water_avg_reg;
            res_soil_ph_reg    <= soil_ph_reg;
            res_water_ph_reg   <= water_ph_reg;
            res_prev_soil_reg  <= prev_soil_reg;
            res_prev_water_reg <= prev_water_reg;
        end
    end

    assign cfg.ready  = 1'b1;
    assign scan.ready = scan_ready;

    assign result.valid             = res_valid_reg;
    assign result.status            = res_status_reg;
    assign result.soil_volts        = res_soil_v_reg;
    assign result.water_volts       = res_water_v_reg;
    assign result.soil_ph_out       = res_soil_ph_reg;
    assign result.water_ph_out      = res_water_ph_reg;
    assign result.prev_soil_ph_out  = res_prev_soil_reg;
    assign result.prev_water_ph_out = res_prev_water_reg;
    assign result.ph_updated        = res_updated_reg;

endmodule

[src/ppal_div.sv]
// ppal_div: restoring divider, one quotient bit per cycle, saturating quotient.
// Depends on ppal_pkg for widths and the request/response structs.

module ppal_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  ppal_pkg::div_req_t req,
    output ppal_pkg::div_rsp_t rsp
);

    logic                               busy_reg, busy_next;
    logic                               done_reg, done_next;
    logic [ppal_pkg::DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    logic                               sat_reg, sat_next;
    logic [ppal_pkg::DIV_NW-1:0]        rem_reg, rem_next;
    logic [ppal_pkg::DIV_SH_W-1:0]      dsh_reg, dsh_next;
    logic [ppal_pkg::DIV_QW-1:0]        quot_reg, quot_next;
    logic [ppal_pkg::DIV_SH_W-1:0]      rem_ext;
    logic [ppal_pkg::DIV_NW-1:0]        num_hi;

    // Load on start, then trial-subtract the shifted divisor once per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        sat_next  = sat_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quot_next = quot_reg;
        rem_ext   = ppal_pkg::DIV_SH_W'(rem_reg);
        num_hi    = req.num >> ppal_pkg::DIV_QW;

        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = ppal_pkg::DIV_CNT_W'(ppal_pkg::DIV_QW);
            // quotient cannot fit: flag saturation, the steps still run
            sat_next  = (num_hi >= ppal_pkg::DIV_NW'(req.den));
            rem_next  = req.num;
            dsh_next  = ppal_pkg::DIV_SH_W'(req.den) << (ppal_pkg::DIV_QW - 1);
            quot_next = '0;
        end
        else if (busy_reg)
        begin
            if (rem_ext >= dsh_reg)
            begin
                rem_next  = ppal_pkg::DIV_NW'(rem_ext - dsh_reg);
                quot_next = {quot_reg[ppal_pkg::DIV_QW-2:0], 1'b1};
            end
            else
            begin
                quot_next = {quot_reg[ppal_pkg::DIV_QW-2:0], 1'b0};
            end
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg - ppal_pkg::DIV_CNT_W'(1);
            if (cnt_reg == ppal_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        sat_reg  <= sat_next;
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        quot_reg <= quot_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = sat_reg ? '1 : quot_reg;

endmodule

[tb/ph_probe_average_linear_test.sv]
`timescale 1ns / 100ps
// ph_probe_average_linear_test: self-checking bench for the pH probe averaging block.
// Depends on ppal_pkg, the ppal_if interfaces and the ph_probe_average_linear RTL.
// Scans are predicted as they are accepted and each result beat is checked in order.

module ph_probe_average_linear_test;

    import ppal_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1000000;

    typedef struct {
        logic [CODE_W-1:0] vref;
        logic [CODE_W-1:0] soil;
        logic [CODE_W-1:0] water;
    } scan_t;

    typedef struct {
        logic                   status;
        logic [VOLT_W-1:0]      soil_v;
        logic [VOLT_W-1:0]      water_v;
        logic signed [PH_W-1:0] soil_ph;
        logic signed [PH_W-1:0] water_ph;
        logic signed [PH_W-1:0] soil_ph_prev;
        logic signed [PH_W-1:0] water_ph_prev;
        logic                   updated;
    } reading_t;

    logic clk;
    logic rst_n;

    ppal_cfg_if    cfg_ch ();
    ppal_scan_if   scan_ch ();
    ppal_result_if res_ch ();

    ph_probe_average_linear u_top
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .scan   (scan_ch),
        .result (res_ch)
    );

    // Register copy, at reset values
    logic [CODE_W-1:0]      cal_code  = 12'd1527;
    logic signed [PH_W-1:0] soil_k    = '0;
    logic signed [PH_W-1:0] soil_b    = '0;
    logic signed [PH_W-1:0] water_k   = '0;
    logic signed [PH_W-1:0] water_b   = '0;
    logic                   cal_mode  = 1'b0;
    logic                   raw_mode  = 1'b0;

    // Block state copy
    int unsigned            blk_count  = 0;
    logic [SUM_W-1:0]       soil_acc   = '0;
    logic [SUM_W-1:0]       water_acc  = '0;
    logic [VOLT_W-1:0]      soil_mean  = '0;
    logic [VOLT_W-1:0]      water_mean = '0;
    logic signed [PH_W-1:0] soil_level = '0;
    logic signed [PH_W-1:0] water_level = '0;
    logic signed [PH_W-1:0] soil_last  = '0;
    logic signed [PH_W-1:0] water_last = '0;

    scan_t       scans_waiting[$];
    reading_t    readings_due[$];
    scan_t       scan_on_bus;
    int unsigned n_sent    = 0;
    int unsigned n_checked = 0;
    int unsigned errors    = 0;
    int unsigned cycles    = 0;

    // Pacing knobs, set per phase by the stimulus
    int unsigned burst_max  = 1;
    int unsigned gap_max    = 0;
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;
    logic [15:0] ready_pat  = 16'hFFFF;
    int unsigned ready_hold = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor arithmetic
    // ------------------------------------------------------------------

    function automatic logic [VOLT_W-1:0] code_to_volts(logic [CODE_W-1:0] code,
                                                        logic [CODE_W-1:0] vref,
                                                        logic [CODE_W-1:0] cal);
        longint num;
        longint den;
        longint q;
        num = longint'(code) * longint'(cal) * 33 * 65536;
        den = longint'(vref) * ADC_FULL_SCALE * 10;
        q   = (num + den / 2) / den;
        return (q > 64'hFFFFF) ? 20'hFFFFF : q[VOLT_W-1:0];
    endfunction

    function automatic logic [SUM_W-1:0] add_sat(logic [SUM_W-1:0] acc,
                                                 logic [VOLT_W-1:0] v);
        longint t;
        t = longint'(acc) + longint'(v);
        return (t > 64'hFFFFFFF) ? 28'hFFFFFFF : t[SUM_W-1:0];
    endfunction

    function automatic logic [VOLT_W-1:0] block_mean(logic [SUM_W-1:0] acc);
        longint q;
        q = (longint'(acc) + AVG_SAMPLES / 2) / AVG_SAMPLES;
        return (q > 64'hFFFFF) ? 20'hFFFFF : q[VOLT_W-1:0];
    endfunction

    // Straight line through the average; the shift floors, as the block rounds half up
    function automatic logic signed [PH_W-1:0] line_fit(logic signed [PH_W-1:0] k,
                                                       logic signed [PH_W-1:0] b,
                                                       logic [VOLT_W-1:0] v);
        longint p;
        longint r;
        if (k == 0 && b == 0)
            return '0;
        p = longint'(k) * longint'(v) + 32768;
        r = (p >>> 16) + longint'(b);
        if (r > 8388607)
            r = 8388607;
        if (r < -8388608)
            r = -8388608;
        return r[PH_W-1:0];
    endfunction

    // Fold one accepted scan into the state copy and queue the reading it gives
    task automatic predict_reading(scan_t s);
        reading_t          rd;
        logic [VOLT_W-1:0] sv;
        logic [VOLT_W-1:0] wv;
        rd.status  = 1'b0;
        rd.updated = 1'b0;
        if (s.vref == 0)
        begin
            rd.status = 1'b1;
        end
        else
        begin
            sv = code_to_volts(s.soil, s.vref, cal_code);
            wv = code_to_volts(s.water, s.vref, cal_code);
            if (!cal_mode)
            begin
                soil_acc  = add_sat(soil_acc, sv);
                water_acc = add_sat(water_acc, wv);
                blk_count++;
                if (blk_count >= AVG_SAMPLES)
                begin
                    soil_mean   = block_mean(soil_acc);
                    water_mean  = block_mean(water_acc);
                    blk_count   = 0;
                    soil_acc    = '0;
                    water_acc   = '0;
                    soil_last   = soil_level;
                    water_last  = water_level;
                    soil_level  = line_fit(soil_k, soil_b, soil_mean);
                    water_level = line_fit(water_k, water_b, water_mean);
                    rd.updated  = 1'b1;
                end
            end
            else
            begin
                if (raw_mode)
                begin
                    soil_mean  = sv;
                    water_mean = wv;
                end
                soil_level  = '0;
                water_level = '0;
            end
        end
        rd.soil_v        = soil_mean;
        rd.water_v       = water_mean;
        rd.soil_ph       = soil_level;
        rd.water_ph      = water_level;
        rd.soil_ph_prev  = soil_last;
        rd.water_ph_prev = water_last;
        readings_due.push_back(rd);
    endtask

    task automatic apply_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] v);
        case (r)
            REG_VREF_FACTORY_CODE: cal_code = v[CODE_W-1:0];
            REG_SOIL_SLOPE:        soil_k   = v;
            REG_SOIL_OFFSET:       soil_b   = v;
            REG_WATER_SLOPE:       water_k  = v;
            REG_WATER_OFFSET:      water_b  = v;
            REG_CALIBRATING:       cal_mode = v[0];
            REG_MEASURE_RAW:       raw_mode = v[0];
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Scan driver: bursts of beats with random gaps between them
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            scan_ch.valid <= 1'b0;
        end
        else
        begin
            if (scan_ch.valid && scan_ch.ready)
                predict_reading(scan_on_bus);
            if (!scan_ch.valid || scan_ch.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    scan_ch.valid <= 1'b0;
                end
                else if (scans_waiting.size() > 0)
                begin
                    scan_on_bus = scans_waiting.pop_front();
                    scan_ch.valid      <= 1'b1;
                    scan_ch.vref_code  <= scan_on_bus.vref;
                    scan_ch.soil_code  <= scan_on_bus.soil;
                    scan_ch.water_code <= scan_on_bus.water;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, burst_max);
                        gap_left   = $urandom_range(0, gap_max);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
                else
                begin
                    scan_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: stalls on a rotating pattern, checks every beat
    // ------------------------------------------------------------------

    task automatic check_field(string name, longint want, longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    task automatic check_reading();
        reading_t rd;
        if (readings_due.size() == 0)
        begin
            $error("result beat with no reading due");
            errors++;
        end
        else
        begin
            rd = readings_due.pop_front();
            check_field("status", rd.status, res_ch.status);
            check_field("soil_volts", rd.soil_v, res_ch.soil_volts);
            check_field("water_volts", rd.water_v, res_ch.water_volts);
            check_field("soil_ph_out", rd.soil_ph, res_ch.soil_ph_out);
            check_field("water_ph_out", rd.water_ph, res_ch.water_ph_out);
            check_field("prev_soil_ph_out", rd.soil_ph_prev, res_ch.prev_soil_ph_out);
            check_field("prev_water_ph_out", rd.water_ph_prev, res_ch.prev_water_ph_out);
            check_field("ph_updated", rd.updated, res_ch.ph_updated);
        end
        n_checked++;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
                check_reading();
            // Pick a new stall pattern now and then; a quarter of them never stall
            if (ready_hold == 0)
            begin
                ready_hold = $urandom_range(16, 96);
                if ($urandom_range(0, 3) == 0)
                    ready_pat = 16'hFFFF;
                else
                    ready_pat = 16'($urandom()) | 16'h0001;
            end
            else
            begin
                ready_hold--;
            end
            res_ch.ready <= ready_pat[0];
            ready_pat = {ready_pat[0], ready_pat[15:1]};
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    task automatic send(logic [CODE_W-1:0] v, logic [CODE_W-1:0] s, logic [CODE_W-1:0] w);
        scan_t sc;
        sc.vref  = v;
        sc.soil  = s;
        sc.water = w;
        scans_waiting.push_back(sc);
        n_sent++;
    endtask

    // Wait for every reading, then a short pause so the block is idle
    task automatic drain();
        while (n_checked < n_sent)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write all seven registers back to back; valid stays high across beats
    task automatic program_regs(logic [CODE_W-1:0] c,
                                logic signed [PH_W-1:0] sk, logic signed [PH_W-1:0] sb,
                                logic signed [PH_W-1:0] wk, logic signed [PH_W-1:0] wb,
                                logic cm, logic rm);
        cfg_reg_t              order [7];
        logic [CFG_DATA_W-1:0] vals [7];
        order = '{REG_VREF_FACTORY_CODE, REG_SOIL_SLOPE, REG_SOIL_OFFSET,
                  REG_WATER_SLOPE, REG_WATER_OFFSET, REG_CALIBRATING, REG_MEASURE_RAW};
        vals  = '{{12'd0, c}, sk, sb, wk, wb, {23'd0, cm}, {23'd0, rm}};
        for (int i = 0; i < 7; i++)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= order[i];
            cfg_ch.data  <= vals[i];
            @(posedge clk);
            while (!cfg_ch.ready)
                @(posedge clk);
            apply_reg(order[i], vals[i]);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic pick_pacing();
        case ($urandom_range(0, 3))
            0:
            begin
                burst_max = 1;
                gap_max   = 0;
            end
            1:
            begin
                burst_max = 16;
                gap_max   = 4;
            end
            2:
            begin
                burst_max = 8;
                gap_max   = 30;
            end
            default:
            begin
                burst_max = 3;
                gap_max   = 100;
            end
        endcase
    endtask

    function automatic logic [CODE_W-1:0] random_code();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 12'hFFF;
            2:       return 12'($urandom_range(1, 15));
            default: return 12'($urandom());
        endcase
    endfunction

    // Mostly plausible scans with the reference near its factory code, some
    // tiny references that saturate the volts, a few zero references
    function automatic scan_t random_scan(logic [CODE_W-1:0] cal);
        scan_t       s;
        int unsigned pick;
        int unsigned lo;
        int unsigned hi;
        pick = $urandom_range(0, 99);
        lo   = (cal > 201) ? cal - 200 : 1;
        hi   = (cal + 200 > 4095) ? 4095 : cal + 200;
        if (pick < 3)
            s.vref = '0;
        else if (pick < 12)
            s.vref = 12'($urandom_range(1, 63));
        else if (pick < 30)
            s.vref = 12'($urandom_range(1, 4095));
        else
            s.vref = 12'($urandom_range(lo, hi));
        s.soil  = random_code();
        s.water = random_code();
        return s;
    endfunction

    function automatic logic signed [PH_W-1:0] any_coeff();
        return 24'($urandom());
    endfunction

    initial
    begin
        logic [CODE_W-1:0]      c;
        logic signed [PH_W-1:0] sk;
        logic signed [PH_W-1:0] sb;
        logic signed [PH_W-1:0] wk;
        logic signed [PH_W-1:0] wb;
        scan_t                  s;
        int unsigned            good;
        int unsigned            target;
        int unsigned            n_cal;

        scan_ch.valid      = 1'b0;
        scan_ch.vref_code  = '0;
        scan_ch.soil_code  = '0;
        scan_ch.water_code = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = REG_VREF_FACTORY_CODE;
        cfg_ch.data        = '0;
        res_ch.ready       = 1'b0;
        rst_n              = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register defaults: zero reference, code extremes, smallest reference
        pick_pacing();
        send(12'd0,    12'd4095, 12'd4095);
        send(12'd4095, 12'd0,    12'd4095);
        send(12'd1,    12'd4095, 12'd1);
        send(12'd1527, 12'd2048, 12'd4095);
        send(12'd4095, 12'd4095, 12'd0);
        drain();

        // Calibration with raw measurement: volts show straight through
        program_regs(12'd4095, 24'sh7FFFFF, 24'sh7FFFFF, -24'sh800000, -24'sh800000,
                     1'b1, 1'b1);
        send(12'd1,    12'd4095, 12'd4095);
        send(12'd4095, 12'd0,    12'd4095);
        send(12'd2048, 12'd1,    12'd2);
        send(12'd0,    12'd123,  12'd456);
        send(12'd4095, 12'd4095, 12'd4095);
        send(12'd1,    12'd1,    12'd0);
        send(12'd3000, 12'd2730, 12'd1365);
        drain();

        // Calibration without raw measurement, zero factory code
        program_regs(12'd0, '0, '0, '0, '0, 1'b1, 1'b0);
        send(12'd1527, 12'd4095, 12'd4095);
        send(12'd0,    12'd0,    12'd0);
        drain();

        // Measuring phases, each long enough to close at least one block,
        // with short calibration stretches between them
        for (int ph = 0; ph < 4; ph++)
        begin
            if (ph > 0)
            begin
                c = ($urandom_range(0, 2) == 0) ? 12'd4095 : 12'($urandom());
                program_regs(c, any_coeff(), any_coeff(), any_coeff(), any_coeff(),
                             1'b1, 1'($urandom()));
                pick_pacing();
                n_cal = $urandom_range(20, 40);
                for (int i = 0; i < n_cal; i++)
                begin
                    s = random_scan(cal_code);
                    send(s.vref, s.soil, s.water);
                end
                drain();
            end

            case (ph)
                0:
                begin
                    // Saturate high on soil, low on water
                    c  = 12'd1527;
                    sk = 24'sh7FFFFF;
                    sb = 24'sh7FFFFF;
                    wk = -24'sh800000;
                    wb = -24'sh800000;
                end
                1:
                begin
                    // Soil with both factors zero, water offset alone
                    c  = 12'd4095;
                    sk = '0;
                    sb = '0;
                    wk = '0;
                    wb = any_coeff() | 24'sd1;
                end
                2:
                begin
                    // Typical probe lines, water without offset
                    c  = 12'd1527;
                    sk = -24'($urandom_range(300000, 450000));
                    sb = 24'($urandom_range(900000, 1600000));
                    wk = -24'($urandom_range(300000, 450000));
                    wb = '0;
                end
                default:
                begin
                    c  = 12'($urandom_range(1, 4095));
                    sk = any_coeff();
                    sb = any_coeff();
                    wk = any_coeff();
                    wb = any_coeff();
                end
            endcase
            program_regs(c, sk, sb, wk, wb, 1'b0, 1'($urandom()));
            pick_pacing();
            good   = 0;
            target = AVG_SAMPLES + $urandom_range(0, 20);
            while (good < target)
            begin
                s = random_scan(cal_code);
                send(s.vref, s.soil, s.water);
                if (s.vref != 0)
                    good++;
            end
            drain();
        end

        repeat (100) @(posedge clk);
        if (readings_due.size() != 0)
        begin
            $error("%0d readings never arrived", readings_due.size());
            errors++;
        end
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
